### src/lkvt_pkg.sv
// Package for the linear key/value table: sizes, command and status codes,
// and the sequencer state type. Depends on nothing; the top level and the testbench use it.
package lkvt_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(10);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_FIND   = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;
    localparam logic [1:0] CMD_DELETE = 2'd3;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_DUP  = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;
    localparam logic [1:0] STAT_MISS = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_VWAIT,
        ST_SHIFT,
        ST_RESP
    } state_t;

endpackage

### src/lkvt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module lkvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### src/linear_key_value_table_top.sv
// Sequencing: an insert into a full table goes straight to the reply, and an empty table
// skips the scan; otherwise the key scan reads one entry per cycle until the key is found
// or all entries are read. A find that hits then reads the value; a delete that hits moves
// the later entries down one slot. Throughput: one item at a time; the next command is
// accepted once the reply is in the result register, and result_stall can hold the reply.
// Reset (rst_n, asynchronous, active low): count to zero, limit to 10, sequencer to idle.
//
// Top level of the linear key/value table. Depends on lkvt_pkg and lkvt_ram.
module linear_key_value_table_top (
    input  logic                         clk,
    input  logic                         rst_n,
    // Configuration: the capacity limit register.
    input  logic                         cfg_we,
    input  logic [lkvt_pkg::CAP_W-1:0]   cfg_wdata,
    // Command channel.
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic [1:0]                   cmd,
    input  logic signed [31:0]           key,
    input  logic signed [31:0]           value,
    // Result channel.
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [1:0]                   status,
    output logic signed [31:0]           found_value,
    output logic [4:0]                   entry_count
);

    localparam int AW = lkvt_pkg::ADDR_W;
    localparam int CW = lkvt_pkg::CNT_W;

    lkvt_pkg::state_t state_reg, state_next;

    logic [1:0]                  cmd_reg, cmd_next;
    logic [lkvt_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [lkvt_pkg::VAL_W-1:0]  val_reg, val_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [lkvt_pkg::CAP_W-1:0]  cap_reg, cap_next;

    // The index counter walks the store during the scan and again during the
    // delete shift, where it points at the entry being read for the move.
    logic [CW-1:0]               idx_reg, idx_next;
    // One read is in flight: during the scan its slot is compared next cycle,
    // during the shift its data is written one slot lower next cycle.
    logic                        pend_reg, pend_next;
    logic [AW-1:0]               pend_idx_reg, pend_idx_next;

    logic                        hit_reg, hit_next;
    logic [AW-1:0]               pos_reg, pos_next;
    logic [1:0]                  st_reg, st_next;
    logic [lkvt_pkg::VAL_W-1:0]  found_reg, found_next;

    logic                        out_valid_reg, out_valid_next;
    logic [1:0]                  out_status_reg, out_status_next;
    logic [lkvt_pkg::VAL_W-1:0]  out_found_reg, out_found_next;
    logic [CW-1:0]               out_count_reg, out_count_next;

    // Shared RAM port controls.
    logic [AW-1:0]               rd_addr;
    logic [AW-1:0]               wr_addr;
    logic                        key_we;
    logic                        val_we;
    logic [lkvt_pkg::KEY_W-1:0]  key_wdata;
    logic [lkvt_pkg::VAL_W-1:0]  val_wdata;
    logic [lkvt_pkg::KEY_W-1:0]  key_rdata;
    logic [lkvt_pkg::VAL_W-1:0]  val_rdata;

    logic                        item_acc;
    logic                        out_free;
    logic [CW-1:0]               limit;
    logic                        is_full;
    logic                        issue;
    logic                        match;
    logic                        walk_done;

    lkvt_ram #(
        .WIDTH (lkvt_pkg::KEY_W),
        .DEPTH (lkvt_pkg::DEPTH)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_we),
        .wr_addr (wr_addr),
        .wr_data (key_wdata),
        .rd_addr (rd_addr),
        .rd_data (key_rdata)
    );

    lkvt_ram #(
        .WIDTH (lkvt_pkg::VAL_W),
        .DEPTH (lkvt_pkg::DEPTH)
    ) u_val_ram (
        .clk     (clk),
        .wr_en   (val_we),
        .wr_addr (wr_addr),
        .wr_data (val_wdata),
        .rd_addr (rd_addr),
        .rd_data (val_rdata)
    );

    // The command side is open whenever the sequencer is idle; a result that
    // still waits in the output register does not hold back the next command.
    assign item_stall = (state_reg != lkvt_pkg::ST_IDLE);
    assign item_acc   = item_valid && !item_stall;
    assign out_free   = !out_valid_reg || !result_stall;

    // The limit in force is the register capped at the store depth.
    assign limit   = (CW'(cap_reg) < CW'(lkvt_pkg::DEPTH)) ? CW'(cap_reg)
                                                           : CW'(lkvt_pkg::DEPTH);
    assign is_full = (count_reg >= limit);

    assign issue     = (idx_reg < count_reg);
    assign match     = pend_reg && (key_rdata == key_reg);
    assign walk_done = !issue && !pend_reg;

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lkvt_pkg::ST_IDLE:
            begin
                if (item_acc)
                begin
                    if ((cmd == lkvt_pkg::CMD_INSERT) && is_full)
                        state_next = lkvt_pkg::ST_RESP;
                    else if (count_reg == '0)
                        state_next = lkvt_pkg::ST_DECIDE;
                    else
                        state_next = lkvt_pkg::ST_SCAN;
                end
            end
            lkvt_pkg::ST_SCAN:
            begin
                if (match || walk_done)
                    state_next = lkvt_pkg::ST_DECIDE;
            end
            lkvt_pkg::ST_DECIDE:
            begin
                if (hit_reg && (cmd_reg == lkvt_pkg::CMD_FIND))
                    state_next = lkvt_pkg::ST_VWAIT;
                else if (hit_reg && (cmd_reg == lkvt_pkg::CMD_DELETE))
                    state_next = lkvt_pkg::ST_SHIFT;
                else
                    state_next = lkvt_pkg::ST_RESP;
            end
            lkvt_pkg::ST_VWAIT:
            begin
                state_next = lkvt_pkg::ST_RESP;
            end
            lkvt_pkg::ST_SHIFT:
            begin
                if (walk_done)
                    state_next = lkvt_pkg::ST_RESP;
            end
            lkvt_pkg::ST_RESP:
            begin
                if (out_free)
                    state_next = lkvt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lkvt_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and RAM control for each state.
    always_comb
    begin
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        count_next    = count_reg;
        cap_next      = cap_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        hit_next      = hit_reg;
        pos_next      = pos_reg;
        st_next       = st_reg;
        found_next    = found_reg;

        out_valid_next  = out_valid_reg && result_stall;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_count_next  = out_count_reg;

        rd_addr   = '0;
        wr_addr   = pos_reg;
        key_we    = 1'b0;
        val_we    = 1'b0;
        key_wdata = key_reg;
        val_wdata = val_reg;

        if (cfg_we)
            cap_next = cfg_wdata;

        unique case (state_reg)
            lkvt_pkg::ST_IDLE:
            begin
                if (item_acc)
                begin
                    cmd_next   = cmd;
                    key_next   = $unsigned(key);
                    val_next   = $unsigned(value);
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    hit_next   = 1'b0;
                    found_next = '0;
                    // A full table wins over a duplicate key on insert.
                    st_next    = ((cmd == lkvt_pkg::CMD_INSERT) && is_full)
                                 ? lkvt_pkg::STAT_FULL : lkvt_pkg::STAT_OK;
                end
            end
            lkvt_pkg::ST_SCAN:
            begin
                if (match)
                begin
                    hit_next  = 1'b1;
                    pos_next  = pend_idx_reg;
                    pend_next = 1'b0;
                end
                else
                begin
                    pend_next = issue;
                    if (issue)
                    begin
                        rd_addr       = idx_reg[AW-1:0];
                        pend_idx_next = idx_reg[AW-1:0];
                        idx_next      = idx_reg + CW'(1);
                    end
                end
            end
            lkvt_pkg::ST_DECIDE:
            begin
                unique case (cmd_reg)
                    lkvt_pkg::CMD_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            st_next = lkvt_pkg::STAT_DUP;
                        end
                        else
                        begin
                            // The count is below the limit here, so it fits the address.
                            wr_addr    = count_reg[AW-1:0];
                            key_we     = 1'b1;
                            val_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    lkvt_pkg::CMD_FIND:
                    begin
                        if (hit_reg)
                            rd_addr = pos_reg;
                        else
                            st_next = lkvt_pkg::STAT_MISS;
                    end
                    lkvt_pkg::CMD_UPDATE:
                    begin
                        if (hit_reg)
                            val_we = 1'b1;
                        else
                            st_next = lkvt_pkg::STAT_MISS;
                    end
                    lkvt_pkg::CMD_DELETE:
                    begin
                        if (hit_reg)
                        begin
                            idx_next  = CW'(pos_reg) + CW'(1);
                            pend_next = 1'b0;
                        end
                        else
                        begin
                            st_next = lkvt_pkg::STAT_MISS;
                        end
                    end
                endcase
            end
            lkvt_pkg::ST_VWAIT:
            begin
                found_next = val_rdata;
            end
            lkvt_pkg::ST_SHIFT:
            begin
                // Read slot idx while the entry read last cycle lands one slot
                // below where it came from. Only occupied slots move.
                if (pend_reg)
                begin
                    wr_addr   = pend_idx_reg;
                    key_wdata = key_rdata;
                    val_wdata = val_rdata;
                    key_we    = 1'b1;
                    val_we    = 1'b1;
                end
                pend_next = issue;
                if (issue)
                begin
                    rd_addr       = idx_reg[AW-1:0];
                    pend_idx_next = idx_reg[AW-1:0] - AW'(1);
                    idx_next      = idx_reg + CW'(1);
                end
                else if (!pend_reg)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            lkvt_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = st_reg;
                    out_found_next  = found_reg;
                    out_count_next  = count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lkvt_pkg::ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= lkvt_pkg::CAP_RESET;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        idx_reg        <= idx_next;
        pend_idx_reg   <= pend_idx_next;
        pos_reg        <= pos_next;
        st_reg         <= st_next;
        found_reg      <= found_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_count_reg  <= out_count_next;
    end

    assign result_valid = out_valid_reg;
    assign status       = out_status_reg;
    assign found_value  = $signed(out_found_reg);
    assign entry_count  = 5'(out_count_reg);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(lkvt_pkg::DEPTH))
        else $error("entry count exceeds the store depth");

    a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lkvt_pkg::ST_SHIFT) |-> (count_reg != '0))
        else $error("delete shift running on an empty table");

    a_found_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (found_value != '0)) |-> (status == lkvt_pkg::STAT_OK))
        else $error("nonzero found value with a failing status");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_acc |=> (state_reg != lkvt_pkg::ST_IDLE))
        else $error("accepted command did not start the sequencer");
`endif

endmodule

### test/tb_top.sv
// Self-checking testbench for the linear key/value table: a scoreboard class predicts
// every reply from its own shadow copy of the table. Depends on lkvt_pkg and the RTL.
module tb_top;
    import lkvt_pkg::*;

    // The watchdog gives up after this many cycles in which neither channel moves a beat.
    localparam int IDLE_LIMIT = 2000;
    // Length of the long receiver hold-off that backs the block up.
    localparam int LONG_HOLD  = 300;
    // Cycles allowed after the last reply for any straggling beat to show up.
    localparam int DRAIN_WAIT = 40;
    localparam int POOL_SIZE  = 24;

    // One expected reply, field for field as the result channel carries it.
    typedef struct packed {
        logic [1:0]       status;
        logic [VAL_W-1:0] found;
        logic [4:0]       count;
    } kv_reply_t;

    // The scoreboard keeps its own copy of the table and the capacity limit. Every
    // command beat that the block accepts is applied to that copy, and the reply it
    // should produce is queued; every reply beat is checked against the oldest one.
    class kv_table_scoreboard;
        logic [KEY_W-1:0] shadow_keys [DEPTH];
        logic [VAL_W-1:0] shadow_vals [DEPTH];
        int               shadow_count;
        logic [CAP_W-1:0] shadow_cap;
        kv_reply_t        pending_replies [$];
        int               errors;
        int               commands;
        int               status_seen [4];

        function new();
            shadow_count = 0;
            shadow_cap   = CAP_RESET;
            errors       = 0;
            commands     = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        function void set_cap(logic [CAP_W-1:0] cap);
            shadow_cap = cap;
        endfunction

        function int outstanding();
            return pending_replies.size();
        endfunction

        // Slot that holds the key, or the entry count when the key is absent.
        function int slot_of(logic [KEY_W-1:0] k);
            for (int i = 0; i < shadow_count; i++)
                if (shadow_keys[i] == k)
                    return i;
            return shadow_count;
        endfunction

        function void note_command(logic [1:0] c, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
            kv_reply_t r;
            int        limit;
            int        pos;
            limit    = (shadow_cap < DEPTH) ? int'(shadow_cap) : DEPTH;
            pos      = slot_of(k);
            r.status = STAT_OK;
            r.found  = '0;
            case (c)
                CMD_INSERT:
                    // A full table wins over a duplicate key.
                    if (shadow_count >= limit)
                        r.status = STAT_FULL;
                    else if (pos < shadow_count)
                        r.status = STAT_DUP;
                    else
                    begin
                        shadow_keys[shadow_count] = k;
                        shadow_vals[shadow_count] = v;
                        shadow_count++;
                    end
                CMD_FIND:
                    if (pos < shadow_count)
                        r.found = shadow_vals[pos];
                    else
                        r.status = STAT_MISS;
                CMD_UPDATE:
                    if (pos < shadow_count)
                        shadow_vals[pos] = v;
                    else
                        r.status = STAT_MISS;
                default:
                    if (pos < shadow_count)
                    begin
                        // Later entries move down one slot; the top slot goes stale.
                        for (int j = pos; j + 1 < shadow_count; j++)
                        begin
                            shadow_keys[j] = shadow_keys[j + 1];
                            shadow_vals[j] = shadow_vals[j + 1];
                        end
                        shadow_count--;
                    end
                    else
                        r.status = STAT_MISS;
            endcase
            r.count = 5'(shadow_count);
            status_seen[r.status]++;
            commands++;
            pending_replies.push_back(r);
        endfunction

        function void check_reply(logic [1:0] st, logic [VAL_W-1:0] fv, logic [4:0] cnt);
            kv_reply_t want;
            if (pending_replies.size() == 0)
            begin
                errors++;
                $display("%0t: reply with nothing expected: status %0d found %h count %0d",
                         $time, st, fv, cnt);
                return;
            end
            want = pending_replies.pop_front();
            if (st !== want.status)
            begin
                errors++;
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, st);
            end
            if (fv !== want.found)
            begin
                errors++;
                $display("%0t: found_value mismatch: expected %h, actual %h",
                         $time, want.found, fv);
            end
            if (cnt !== want.count)
            begin
                errors++;
                $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                         $time, want.count, cnt);
            end
        endfunction
    endclass

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    cfg_we       = 1'b0;
    logic [CAP_W-1:0]        cfg_wdata    = '0;
    logic                    item_valid   = 1'b0;
    logic                    item_stall;
    logic [1:0]              cmd          = CMD_FIND;
    logic [KEY_W-1:0]        key          = '0;
    logic [VAL_W-1:0]        value        = '0;
    logic                    result_valid;
    logic                    result_stall = 1'b0;
    logic [1:0]              status;
    logic [VAL_W-1:0]        found_value;
    logic [4:0]              entry_count;

    kv_table_scoreboard      table_sb;
    logic [KEY_W-1:0]        key_pool [POOL_SIZE];

    // Sender burst state, the receiver's own cycle count and hold-off bookkeeping.
    int burst_left  = 0;
    int rx_cycle    = 0;
    int stall_mode  = 0;
    int hold_asks   = 0;
    int hold_served = 0;
    int hold_left   = 0;
    int idle_cycles = 0;
    int limit_writes = 0;

    linear_key_value_table_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .cmd          (cmd),
        .key          (key),
        .value        (value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .found_value  (found_value),
        .entry_count  (entry_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Offers one command beat and returns at the edge that accepts it. The sender works
    // in bursts: when a burst runs out it drops valid for a random gap (sometimes none)
    // and picks the length of the next burst. Valid is only ever raised in a time step
    // where it was not also lowered.
    task automatic send_item(input logic [1:0] c, input logic [KEY_W-1:0] k,
                             input logic [VAL_W-1:0] v);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        item_valid <= 1'b1;
        cmd        <= c;
        key        <= k;
        value      <= v;
        do
            @(posedge clk);
        while (!(item_valid && !item_stall));
        table_sb.note_command(c, k, v);
        burst_left--;
    endtask

    // The capacity limit is only written once every reply is back. Every command
    // produces exactly one reply, so an empty expectation queue means the block is idle.
    task automatic write_limit(input logic [CAP_W-1:0] cap);
        item_valid <= 1'b0;
        while (table_sb.outstanding() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we <= 1'b0;
        table_sb.set_cap(cap);
        limit_writes++;
    endtask

    // Random traffic. Most keys come from a small pool so that finds, updates, deletes
    // and duplicates actually hit stored entries; the rest are fully random 32-bit keys.
    // When hold_at is reached the receiver is asked for one long hold-off.
    task automatic random_phase(input int n, input int insert_pct, input int pool_n,
                                input int hold_at);
        logic [1:0]       c;
        logic [KEY_W-1:0] k;
        logic [VAL_W-1:0] v;
        for (int i = 0; i < n; i++)
        begin
            if (i == hold_at)
                hold_asks++;
            if ($urandom_range(0, 99) < insert_pct)
                c = CMD_INSERT;
            else
                case ($urandom_range(0, 2))
                    0:       c = CMD_FIND;
                    1:       c = CMD_UPDATE;
                    default: c = CMD_DELETE;
                endcase
            k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, pool_n - 1)];
            case ($urandom_range(0, 15))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7fff_ffff;
                default: v = $urandom;
            endcase
            send_item(c, k, v);
        end
    endtask

    // Receiver: checks every reply beat and drives stall. The stall pattern cycles
    // through four modes in turn (never, light random, heavy random and a
    // fixed two-in-five rhythm), and a pending hold-off request overrides it all.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                table_sb.check_reply(status, found_value, entry_count);
            if (hold_served != hold_asks)
            begin
                hold_served = hold_asks;
                hold_left   = LONG_HOLD;
            end
            stall_mode = (rx_cycle / 128) % 4;
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                case (stall_mode)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 3) == 0);
                    2:       result_stall <= ($urandom_range(0, 3) != 0);
                    default: result_stall <= ((rx_cycle % 5) < 2);
                endcase
            rx_cycle++;
        end
    end

    // Watchdog: any beat on either channel restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles, %0d replies still expected",
                         $time, IDLE_LIMIT, table_sb.outstanding());
                $display("FAIL linear_key_value_table_top");
                $finish;
            end
        end
    end

    initial
    begin
        table_sb = new();
        // The pool always holds the extreme key patterns; the rest are random.
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, at the reset limit of 10. An empty table misses on every
        // lookup, then the extreme keys go in with extreme values.
        send_item(CMD_FIND,   32'h0000_0000, 32'h0000_0000);
        send_item(CMD_UPDATE, 32'h8000_0000, 32'h1111_1111);
        send_item(CMD_DELETE, 32'hffff_ffff, 32'h0000_0000);
        send_item(CMD_INSERT, 32'h8000_0000, 32'h7fff_ffff);
        send_item(CMD_INSERT, 32'h7fff_ffff, 32'h8000_0000);
        send_item(CMD_INSERT, 32'h0000_0000, 32'hffff_ffff);
        send_item(CMD_INSERT, 32'hffff_ffff, 32'h0000_0000);
        // A duplicate key is refused while there is still room.
        send_item(CMD_INSERT, 32'h8000_0000, 32'h5555_5555);
        send_item(CMD_FIND,   32'h7fff_ffff, 32'h0000_0000);
        send_item(CMD_UPDATE, 32'h0000_0000, 32'h1234_5678);
        send_item(CMD_FIND,   32'h0000_0000, 32'hffff_ffff);
        // Deleting the first entry shifts the other three down; deleting the last
        // entry shifts nothing.
        send_item(CMD_DELETE, 32'h8000_0000, 32'h0000_0000);
        send_item(CMD_FIND,   32'hffff_ffff, 32'h0000_0000);
        send_item(CMD_DELETE, 32'hffff_ffff, 32'h0000_0000);
        // Fill to the limit, then a new key and a stored key both see a full table.
        for (int i = 0; i < 8; i++)
            send_item(CMD_INSERT, $urandom, $urandom);
        send_item(CMD_INSERT, 32'h0bad_f00d, 32'h0000_0001);
        send_item(CMD_INSERT, 32'h0000_0000, 32'h0000_0002);
        send_item(CMD_DELETE, 32'h7fff_ffff, 32'h0000_0000);

        // Random part across several limit settings. The first and the fifth phase each carry a long
        // hold-off, during which the sender keeps offering and the block backs up.
        write_limit(CAP_W'(DEPTH));
        random_phase(300, 45, 12, 60);
        // Fill the table completely, then lower the limit well below the count.
        random_phase(40, 100, POOL_SIZE, -1);
        write_limit(CAP_W'(3));
        random_phase(200, 25, POOL_SIZE, -1);
        // A limit of zero refuses every insert.
        write_limit(CAP_W'(0));
        random_phase(100, 40, POOL_SIZE, -1);
        // The largest register value is capped at the table depth.
        write_limit(CAP_W'(31));
        random_phase(250, 50, 20, 120);
        write_limit(CAP_W'(1));
        random_phase(100, 40, 6, -1);
        write_limit(CAP_W'($urandom_range(2, 15)));
        random_phase(300, 40, 16, -1);

        item_valid <= 1'b0;
        while (table_sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d commands over %0d limit writes, including a long receiver hold-off.",
                 table_sb.commands, limit_writes);
        $display("Replies: %0d ok, %0d duplicate, %0d full, %0d missing key; %0d mismatches.",
                 table_sb.status_seen[STAT_OK], table_sb.status_seen[STAT_DUP],
                 table_sb.status_seen[STAT_FULL], table_sb.status_seen[STAT_MISS],
                 table_sb.errors);
        if (table_sb.errors == 0)
            $display("PASS linear_key_value_table_top");
        else
            $display("FAIL linear_key_value_table_top");
        $finish;
    end

endmodule

### linear_key_value_table_top.f
src/lkvt_pkg.sv
src/lkvt_ram.sv
src/linear_key_value_table_top.sv
test/tb_top.sv
